FILE: hdl/bse_pkg.sv
// Shared definitions for the bubble sort engine: default sizes and the
// command and status bundles between the controller and the datapath.
// Depends on nothing; bubble_sort_engine, bse_ctrl and bse_dp import it.
package bse_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Commands issued by the controller, one group per controller state.
  typedef struct packed {
    logic store;       // Input transaction accepted; keep its value if room.
    logic set_end;     // The accepted transaction closes the set.
    logic sort_start;  // Fetch element 0 for the first pass.
    logic first;       // Latch element 0 as the carried value, fetch element 1.
    logic pair;        // Compare the carried value with the fetched neighbor.
    logic pass_end;    // Write the carried value at the pass limit.
    logic emit_start;  // Fetch element 0 for output.
    logic emit_step;   // Move a fetched element to the output register.
  } cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic single;      // Buffer is empty, so a closing item makes a set of one.
    logic last_pair;   // Current pair is the final one of this pass.
    logic pass_done;   // Current pass is the final one.
    logic emit_last;   // Element being sent is the final one of the set.
    logic out_free;    // Output register can take an element this cycle.
  } sts_t;

endpackage

FILE: hdl/bubble_sort_engine.sv
// Top level of the bubble sort engine: stable ascending sort of a set of
// signed values. Depends on bse_pkg, bse_ctrl, bse_dp (and bse_ram below it).
//
//   Channel  Dir  Handshake          Payload
//   s_*      in   s_tvalid/s_tready  s_tdata: value; s_tlast: last_item
//   m_*      out  m_tvalid/m_tready  m_tdata: sorted_value; m_tlast: last_result
//
// Loading accepts one input transaction per cycle while s_tvalid is high.
// Once a set of n elements is closed, with n of two or more, the sort runs
// S_PASS and then, for every pass, S_FIRST, one S_PAIR step per compare and
// swap, and S_PEND; the compares and swaps share the single write and
// single read port of the element buffer. A set of one element skips the
// sort. Output then runs through S_EMIT_RD and S_EMIT; a stall simply holds
// the output register and the buffer read. Reset returns the engine to
// loading with an empty buffer; buffer contents are not cleared, as only
// written entries are ever read. A new set may start loading while the
// final result of the previous set still waits in the output register.
module bubble_sort_engine #(
  parameter int DEPTH       = bse_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bse_pkg::VALUE_WIDTH_DEF,
  parameter int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_WIDTH-1:0] s_tdata,   // From bit 0: value, then zero fill.
  input  logic                   s_tlast,   // Marks the final element of a set.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_WIDTH-1:0] m_tdata,   // From bit 0: sorted_value, then zero fill.
  output logic                   m_tlast    // Marks the final sorted element.
);

  import bse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns the sequence; the datapath owns all storage.
  bse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tlast (s_tlast),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  bse_dp #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .TDATA_WIDTH(TDATA_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // A set of one element skips sorting and goes straight to output.
  a_single_skips_sort: assert property (@(posedge clk) disable iff (rst)
    (cmd.set_end && sts.single) |=> cmd.emit_start)
    else $error("single-element set did not go straight to output");

  // A larger set stops input while it is sorted.
  a_sort_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.set_end && !sts.single) |=> !s_tready)
    else $error("input accepted while a set is being sorted");

  // Handing over the final element returns the engine to loading.
  a_final_reopens_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_step && sts.out_free && sts.emit_last) |=> (s_tready && m_tvalid && m_tlast))
    else $error("engine did not return to loading after the final element");

  // The buffer is never written while elements are being sent out.
  a_no_store_in_output: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |-> !(cmd.store || cmd.pair || cmd.pass_end))
    else $error("buffer written during output");

endmodule

FILE: hdl/bse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bse_dp.sv
// Datapath of the bubble sort engine: element buffer, carried value,
// indexes, comparator and output register.
// Depends on bse_pkg and bse_ram.
module bse_dp #(
  parameter int DEPTH       = bse_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = bse_pkg::VALUE_WIDTH_DEF,
  parameter int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bse_pkg::cmd_t          cmd,
  output bse_pkg::sts_t          sts,
  input  logic [TDATA_WIDTH-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_WIDTH-1:0] m_tdata,
  output logic                   m_tlast
);

  import bse_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]          count;
  logic [AW-1:0]          lim;
  logic [AW-1:0]          nlast;
  logic [AW-1:0]          j;
  logic [AW-1:0]          k;
  logic [VALUE_WIDTH-1:0] cur;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rdata;

  logic full;
  logic gt;
  logic out_load;

  assign full     = (count == CW'(DEPTH));
  assign gt       = $signed(cur) > $signed(rdata);
  assign out_load = cmd.emit_step && sts.out_free;

  assign sts.single    = (count == '0);
  assign sts.last_pair = (j == lim - AW'(1));
  assign sts.pass_done = (lim == AW'(1));
  assign sts.emit_last = (k == nlast);
  assign sts.out_free  = !m_tvalid || m_tready;

  // Buffer port steering.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = cur;
    re    = 1'b0;
    raddr = '0;
    if (cmd.store && !full) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = s_tdata[VALUE_WIDTH-1:0];
    end
    if (cmd.sort_start || cmd.pass_end || cmd.emit_start) begin
      re = 1'b1;
    end
    if (cmd.first) begin
      re    = 1'b1;
      raddr = AW'(1);
    end
    if (cmd.pair) begin
      we    = 1'b1;
      waddr = j;
      wdata = gt ? rdata : cur;
      re    = !sts.last_pair;
      raddr = j + AW'(2);
    end
    if (cmd.pass_end) begin
      we    = 1'b1;
      waddr = lim;
      wdata = cur;
    end
    if (out_load) begin
      re    = !sts.emit_last;
      raddr = k + AW'(1);
    end
  end

  bse_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.set_end) begin
      count <= '0;
    end else if (cmd.store && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_end) begin
      lim   <= full ? AW'(DEPTH - 1) : count[AW-1:0];
      nlast <= full ? AW'(DEPTH - 1) : count[AW-1:0];
    end else if (cmd.pass_end) begin
      lim <= lim - AW'(1);
    end
    if (cmd.first) begin
      cur <= rdata;
      j   <= '0;
    end else if (cmd.pair) begin
      cur <= gt ? cur : rdata;
      j   <= j + AW'(1);
    end
    if (cmd.emit_start) begin
      k <= '0;
    end else if (out_load) begin
      k <= k + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= TDATA_WIDTH'(rdata);
      m_tlast <= sts.emit_last;
    end
  end

endmodule

FILE: hdl/bse_ctrl.sv
// Controller of the bubble sort engine: the state machine that sequences
// loading, the sort passes and the output of one set.
// Depends on bse_pkg.
module bse_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tlast,
  output logic          s_tready,
  input  bse_pkg::sts_t sts,
  output bse_pkg::cmd_t cmd
);

  import bse_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_PASS    = 7'b0000010,
    S_FIRST   = 7'b0000100,
    S_PAIR    = 7'b0001000,
    S_PEND    = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_LOAD);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.store      = accept;
    cmd.set_end    = accept && s_tlast;
    unique case (state)
      S_LOAD: begin
        if (accept && s_tlast) begin
          state_next = sts.single ? S_EMIT_RD : S_PASS;
        end
      end
      S_PASS: begin
        cmd.sort_start = 1'b1;
        state_next     = S_FIRST;
      end
      S_FIRST: begin
        cmd.first  = 1'b1;
        state_next = S_PAIR;
      end
      S_PAIR: begin
        cmd.pair = 1'b1;
        if (sts.last_pair) begin
          state_next = S_PEND;
        end
      end
      S_PEND: begin
        cmd.pass_end = 1'b1;
        state_next   = sts.pass_done ? S_EMIT_RD : S_FIRST;
      end
      S_EMIT_RD: begin
        cmd.emit_start = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (sts.out_free && sts.emit_last) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
